@@ rtl/core/file_url_to_path_decoder_core_macros.svh @@
// Assertion shorthands for the file URL decoder.
`ifndef FILE_URL_TO_PATH_DECODER_CORE_MACROS_SVH
`define FILE_URL_TO_PATH_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define FUPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define FUPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FUPD_ASSERT(lbl, clk, rst, prop, msg)
`define FUPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/fupd_pkg.sv @@
package fupd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic [1:0] status;
  } out_item_t;

  // Results of one item, handed to the output buffer.
  typedef struct packed {
    logic [1:0]           count;
    out_item_t [2:0]      items;
  } res_set_t;

  typedef enum logic [8:0] {
    PH_START  = 9'b000000001,
    PH_HELD   = 9'b000000010,
    PH_PREFIX = 9'b000000100,
    PH_SLASH1 = 9'b000001000,
    PH_SLASH2 = 9'b000010000,
    PH_HOST   = 9'b000100000,
    PH_LOCAL  = 9'b001000000,
    PH_PATH   = 9'b010000000,
    PH_DROP   = 9'b100000000
  } phase_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFILE  = 2'd1;
  localparam logic [1:0] ST_NOPATH   = 2'd2;
  localparam logic [1:0] ST_NONLOCAL = 2'd3;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam logic [3:0] SCHEME_LEN = 4'd5;
  localparam logic [3:0] LOCAL_LEN  = 4'd10;

  typedef struct packed {
    logic       emit;
    logic [7:0] value;
    logic [1:0] stage;
    logic [7:0] high;
  } esc_t;

  // "file:"
  function automatic logic [7:0] scheme_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h66;
      4'd1:    ch = 8'h69;
      4'd2:    ch = 8'h6C;
      4'd3:    ch = 8'h65;
      4'd4:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "localhost/"
  function automatic logic [7:0] local_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h6C;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h63;
      4'd3:    ch = 8'h61;
      4'd4:    ch = 8'h6C;
      4'd5:    ch = 8'h68;
      4'd6:    ch = 8'h6F;
      4'd7:    ch = 8'h73;
      4'd8:    ch = 8'h74;
      4'd9:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Digits and upper-case A-F map normally; anything else wraps as c - 'a' + 10.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v;
  endfunction

  // One path byte through the %HH escape decoder.
  function automatic esc_t esc_step(input logic [7:0] c, input logic [1:0] stage,
                                    input logic [7:0] high);
    esc_t r;
    logic [7:0] hv;
    hv      = hex_value(c);
    r.emit  = 1'b0;
    r.value = c;
    r.stage = stage;
    r.high  = high;
    case (stage)
      ESC_HIGH: begin
        r.high  = {hv[3:0], 4'b0000};
        r.stage = ESC_LOW;
      end
      ESC_LOW: begin
        r.emit  = 1'b1;
        r.value = high + hv;
        r.stage = ESC_IDLE;
      end
      default: begin
        if (c == CH_PERCENT) begin
          r.stage = ESC_HIGH;
        end else begin
          r.emit = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/fupd_step.sv @@
// URL parse state and per-item result generation.
module fupd_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  fupd_pkg::in_item_t item,
  output fupd_pkg::res_set_t res
);

  fupd_pkg::phase_t ph, ph_next;
  logic [3:0] match_count, match_count_next;
  logic [7:0] held_byte, held_byte_next;
  logic [1:0] escape_stage, escape_stage_next;
  logic [7:0] escape_high, escape_high_next;
  logic [1:0] error_code, error_code_next;

  always_comb begin
    fupd_pkg::esc_t d;
    logic [7:0] c;
    logic [1:0] n;
    logic [1:0] st;
    fupd_pkg::out_item_t [2:0] items;

    c                 = item.in_byte;
    n                 = 2'd0;
    st                = fupd_pkg::ST_OK;
    items             = '0;
    d                 = '0;
    ph_next           = ph;
    match_count_next  = match_count;
    held_byte_next    = held_byte;
    escape_stage_next = escape_stage;
    escape_high_next  = escape_high;
    error_code_next   = error_code;

    case (ph)
      fupd_pkg::PH_START: begin
        if (c == fupd_pkg::CH_SLASH) begin
          ph_next = fupd_pkg::PH_PATH;
          items[n] = '{out_byte: c, is_end: 1'b0, status: fupd_pkg::ST_OK};
          n = n + 2'd1;
        end else if (fupd_pkg::is_letter(c)) begin
          held_byte_next = c;
          ph_next        = fupd_pkg::PH_HELD;
        end else begin
          error_code_next = fupd_pkg::ST_NOTFILE;
          ph_next         = fupd_pkg::PH_DROP;
        end
      end
      fupd_pkg::PH_HELD: begin
        if ((c == fupd_pkg::CH_BAR) || (c == fupd_pkg::CH_COLON)) begin
          ph_next = fupd_pkg::PH_PATH;
          items[n] = '{out_byte: held_byte, is_end: 1'b0, status: fupd_pkg::ST_OK};
          n = n + 2'd1;
          items[n] = '{out_byte: c, is_end: 1'b0, status: fupd_pkg::ST_OK};
          n = n + 2'd1;
        end else if ((held_byte == fupd_pkg::scheme_char(4'd0)) &&
                     (c == fupd_pkg::scheme_char(4'd1))) begin
          match_count_next = 4'd2;
          ph_next          = fupd_pkg::PH_PREFIX;
        end else begin
          error_code_next = fupd_pkg::ST_NOTFILE;
          ph_next         = fupd_pkg::PH_DROP;
        end
      end
      fupd_pkg::PH_PREFIX: begin
        if ((match_count < fupd_pkg::SCHEME_LEN) &&
            (c == fupd_pkg::scheme_char(match_count))) begin
          match_count_next = match_count + 4'd1;
          if (match_count_next == fupd_pkg::SCHEME_LEN) begin
            ph_next = fupd_pkg::PH_SLASH1;
          end
        end else begin
          error_code_next = fupd_pkg::ST_NOTFILE;
          ph_next         = fupd_pkg::PH_DROP;
        end
      end
      fupd_pkg::PH_SLASH1: begin
        if (c == fupd_pkg::CH_SLASH) begin
          ph_next = fupd_pkg::PH_SLASH2;
        end else begin
          error_code_next = fupd_pkg::ST_NOPATH;
          ph_next         = fupd_pkg::PH_DROP;
        end
      end
      fupd_pkg::PH_SLASH2: begin
        if (c == fupd_pkg::CH_SLASH) begin
          ph_next = fupd_pkg::PH_HOST;
        end else begin
          // file:/path: the slash already seen opens the path
          ph_next = fupd_pkg::PH_PATH;
          items[n] = '{out_byte: fupd_pkg::CH_SLASH, is_end: 1'b0, status: fupd_pkg::ST_OK};
          n = n + 2'd1;
          d = fupd_pkg::esc_step(c, escape_stage, escape_high);
          escape_stage_next = d.stage;
          escape_high_next  = d.high;
          if (d.emit) begin
            items[n] = '{out_byte: d.value, is_end: 1'b0, status: fupd_pkg::ST_OK};
            n = n + 2'd1;
          end
        end
      end
      fupd_pkg::PH_HOST: begin
        if (c == fupd_pkg::CH_SLASH) begin
          ph_next = fupd_pkg::PH_PATH;
          items[n] = '{out_byte: c, is_end: 1'b0, status: fupd_pkg::ST_OK};
          n = n + 2'd1;
        end else if (c == fupd_pkg::local_char(4'd0)) begin
          match_count_next = 4'd1;
          ph_next          = fupd_pkg::PH_LOCAL;
        end else begin
          error_code_next = fupd_pkg::ST_NONLOCAL;
          ph_next         = fupd_pkg::PH_DROP;
        end
      end
      fupd_pkg::PH_LOCAL: begin
        if ((match_count < fupd_pkg::LOCAL_LEN) &&
            (c == fupd_pkg::local_char(match_count))) begin
          match_count_next = match_count + 4'd1;
          if (match_count_next == fupd_pkg::LOCAL_LEN) begin
            ph_next = fupd_pkg::PH_PATH;
            items[n] = '{out_byte: c, is_end: 1'b0, status: fupd_pkg::ST_OK};
            n = n + 2'd1;
          end
        end else begin
          error_code_next = fupd_pkg::ST_NONLOCAL;
          ph_next         = fupd_pkg::PH_DROP;
        end
      end
      fupd_pkg::PH_PATH: begin
        d = fupd_pkg::esc_step(c, escape_stage, escape_high);
        escape_stage_next = d.stage;
        escape_high_next  = d.high;
        if (d.emit) begin
          items[n] = '{out_byte: d.value, is_end: 1'b0, status: fupd_pkg::ST_OK};
          n = n + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (item.in_last) begin
      case (ph_next)
        fupd_pkg::PH_PATH:   st = fupd_pkg::ST_OK;
        fupd_pkg::PH_SLASH2: begin
          // "file:/" alone names the root
          items[n] = '{out_byte: fupd_pkg::CH_SLASH, is_end: 1'b0, status: fupd_pkg::ST_OK};
          n = n + 2'd1;
          st = fupd_pkg::ST_OK;
        end
        fupd_pkg::PH_SLASH1: st = fupd_pkg::ST_NOPATH;
        fupd_pkg::PH_HOST:   st = fupd_pkg::ST_NONLOCAL;
        fupd_pkg::PH_LOCAL:  st = fupd_pkg::ST_NONLOCAL;
        fupd_pkg::PH_DROP:   st = error_code_next;
        default:             st = fupd_pkg::ST_NOTFILE;
      endcase
      items[n] = '{out_byte: 8'h00, is_end: 1'b1, status: st};
      n = n + 2'd1;
      // a cut-short escape is simply discarded here
      ph_next           = fupd_pkg::PH_START;
      match_count_next  = 4'd0;
      held_byte_next    = 8'h00;
      escape_stage_next = fupd_pkg::ESC_IDLE;
      escape_high_next  = 8'h00;
      error_code_next   = fupd_pkg::ST_OK;
    end

    res.count = n;
    res.items = items;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph           <= fupd_pkg::PH_START;
      match_count  <= 4'd0;
      held_byte    <= 8'h00;
      escape_stage <= fupd_pkg::ESC_IDLE;
      escape_high  <= 8'h00;
      error_code   <= fupd_pkg::ST_OK;
    end else if (advance) begin
      ph           <= ph_next;
      match_count  <= match_count_next;
      held_byte    <= held_byte_next;
      escape_stage <= escape_stage_next;
      escape_high  <= escape_high_next;
      error_code   <= error_code_next;
    end
  end

endmodule

@@ rtl/core/fupd_outbuf.sv @@
// Three-slot result register, drained one item per cycle while out_ready is high.
module fupd_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fupd_pkg::res_set_t  res,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output fupd_pkg::out_item_t out_item
);

  fupd_pkg::out_item_t [2:0] slots;
  logic [1:0] count;
  logic [1:0] rd;

  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd];
  // free now, or the last waiting item leaves this cycle
  assign can_load  = (count == 2'd0) || ((count == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rd    <= 2'd0;
    end else if (load) begin
      count <= res.count;
      rd    <= 2'd0;
    end else if (out_valid && out_ready) begin
      count <= count - 2'd1;
      rd    <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= res.items;
    end
  end

endmodule

@@ rtl/core/file_url_to_path_decoder_core.sv @@
// File URL to local path decoder. Takes a URL one byte per item (in_last on
// the final byte) and returns the local path it names, one decoded byte per
// result item, followed by a closing item (is_end = 1) that carries the
// status: 0 success, 1 not a file URL, 2 missing path, 3 non-local host.
// Accepted forms are a bare path ("/..." or a letter then '|' or ':') and
// file:/path, file:///path, file://localhost/path; %HH escapes are decoded.
// Rate: an item that yields at most one result moves through at one item
// per cycle while out_ready is high; one that yields two or three results
// holds the input until the single output port, draining the result
// register one item per cycle while out_ready is high, takes the last of
// them. An accepted item passes through the input register and then the
// result register before its first result is offered on the output.
`include "file_url_to_path_decoder_core_macros.svh"

module file_url_to_path_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fupd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fupd_pkg::out_item_t out_item
);

  // Input register
  logic               in_vld;
  fupd_pkg::in_item_t in_q;

  fupd_pkg::res_set_t res;
  logic               can_load;
  logic               advance;

  // The registered item is decoded once the result register can take all
  // of its results.
  assign advance  = in_vld && can_load;
  assign in_ready = !in_vld || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  // Parse state, escape decoder, result generation
  fupd_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .res     (res)
  );

  // Result register toward the output channel
  fupd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Checks
  `FUPD_ASSERT(a_blocked_item_held, clk, rst, (in_vld && !can_load) |=> in_vld, "blocked item lost")
  `FUPD_ASSERT(a_accept_lands, clk, rst, (in_valid && in_ready) |=> in_vld, "accepted item not registered")
  `FUPD_ASSERT(a_result_shape, clk, rst, (out_valid && out_item.is_end) |-> (out_item.out_byte == 8'h00), "closing item with data")
  `FUPD_ASSERT(a_path_status, clk, rst, (out_valid && !out_item.is_end) |-> (out_item.status == fupd_pkg::ST_OK), "path byte with status")
  `FUPD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result after reset")

endmodule
